FILE: rtl/core/psp_pkg.sv
package psp_pkg;

    localparam int COORD_BITS     = 20;
    localparam int RADIUS_BITS    = 20;
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(51);

    localparam int DIFF_BITS      = COORD_BITS + 1;
    localparam int PROD_BITS      = 2 * DIFF_BITS;
    localparam int DOT_BITS       = PROD_BITS + 2;
    localparam int MAG_BITS       = PROD_BITS;
    localparam int HALF_LO        = MAG_BITS / 2;
    localparam int HALF_HI        = MAG_BITS - HALF_LO;
    localparam int SQ_BITS        = 2 * MAG_BITS;
    localparam int SUM_BITS       = SQ_BITS + 2;
    localparam int R2_BITS        = 2 * RADIUS_BITS;
    localparam int R2_LO          = R2_BITS / 2;
    localparam int R2_HI          = R2_BITS - R2_LO;
    localparam int L_LO           = DOT_BITS / 2;
    localparam int L_HI           = DOT_BITS - L_LO;
    localparam int R2L_BITS       = R2_BITS + DOT_BITS;

    localparam int IN_FIELDS      = 9;
    localparam int IN_TDATA_BITS  = ((IN_FIELDS * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = 8;
    localparam int STAGES         = 7;

    typedef enum logic [1:0] {
        REGION_START    = 2'd0,
        REGION_INTERIOR = 2'd1,
        REGION_END      = 2'd2
    } region_t;

    typedef struct packed {
        logic [2*HALF_HI-1:0]         hh;
        logic [HALF_HI+HALF_LO-1:0]   hl;
        logic [2*HALF_LO-1:0]         ll;
    } sq_parts_t;

endpackage

FILE: rtl/core/psp_sq_parts.sv
module psp_sq_parts
    import psp_pkg::*;
(
    input  logic [MAG_BITS-1:0] mag,
    output sq_parts_t           parts
);

    logic [HALF_HI-1:0] hi;
    logic [HALF_LO-1:0] lo;

    assign hi = mag[MAG_BITS-1:HALF_LO];
    assign lo = mag[HALF_LO-1:0];

    // mag^2 = hh << 2*HALF_LO + hl << (HALF_LO+1) + ll
    assign parts.hh = (2*HALF_HI)'(hi) * (2*HALF_HI)'(hi);
    assign parts.hl = (HALF_HI+HALF_LO)'(hi) * (HALF_HI+HALF_LO)'(lo);
    assign parts.ll = (2*HALF_LO)'(lo) * (2*HALF_LO)'(lo);

endmodule

FILE: rtl/core/point_segment_proximity_test.sv
// Throughput: one word per cycle; a stall on m_tready holds each valid
// stage with no bubble after it, and a bubble in any stage is filled while
// later stages wait.
// The rate is set by the seven-stage multiply and wide-compare pipeline.
// Reset: rst_n clears all valid bits and sets hit_radius to 51.
module point_segment_proximity_test
    import psp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [RADIUS_BITS-1:0]    cfg_data,   // hit_radius

    input  logic                      s_tvalid,
    output logic                      s_tready,
    // seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y, seg_end_z,
    // query_x, query_y, query_z (20 bits each), zero pad
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,

    output logic                      m_tvalid,
    input  logic                      m_tready,
    // hit (1), closest_region (2), zero pad
    output logic [OUT_TDATA_BITS-1:0] m_tdata
);

    logic [RADIUS_BITS-1:0] hit_radius_reg;
    logic [STAGES-1:0]      vld_reg;
    logic [STAGES-1:0]      vld_next;
    logic [STAGES-1:0]      en;

    // config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_radius_reg <= RADIUS_RESET;
        end
        else if (cfg_valid)
        begin
            hit_radius_reg <= cfg_data;
        end
    end

    // pipeline flow control
    always_comb
    begin
        en[STAGES-1] = !vld_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign vld_next = {vld_reg[STAGES-2:0], s_tvalid};
    assign s_tready = en[0];
    assign m_tvalid = vld_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= (en & vld_next) | (~en & vld_reg);
        end
    end

    // stage 1: differences
    logic signed [COORD_BITS-1:0] pa [3];
    logic signed [COORD_BITS-1:0] pb [3];
    logic signed [COORD_BITS-1:0] pq [3];
    logic signed [DIFF_BITS-1:0]  d_next [3];
    logic signed [DIFF_BITS-1:0]  w_next [3];
    logic signed [DIFF_BITS-1:0]  v_next [3];
    logic signed [DIFF_BITS-1:0]  d_reg [3];
    logic signed [DIFF_BITS-1:0]  w_reg [3];
    logic signed [DIFF_BITS-1:0]  v_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pa[k] = s_tdata[k*COORD_BITS +: COORD_BITS];
            pb[k] = s_tdata[(k+3)*COORD_BITS +: COORD_BITS];
            pq[k] = s_tdata[(k+6)*COORD_BITS +: COORD_BITS];
            d_next[k] = DIFF_BITS'(pb[k]) - DIFF_BITS'(pa[k]);
            w_next[k] = DIFF_BITS'(pq[k]) - DIFF_BITS'(pa[k]);
            v_next[k] = DIFF_BITS'(pq[k]) - DIFF_BITS'(pb[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d_reg <= d_next;
            w_reg <= w_next;
            v_reg <= v_next;
        end
    end

    // stage 2: products
    logic signed [PROD_BITS-1:0] wd_next [3][3];
    logic signed [PROD_BITS-1:0] dd_next [3];
    logic signed [PROD_BITS-1:0] ww_next [3];
    logic signed [PROD_BITS-1:0] vv_next [3];
    logic signed [PROD_BITS-1:0] wd_reg [3][3];
    logic signed [PROD_BITS-1:0] dd_reg [3];
    logic signed [PROD_BITS-1:0] ww_reg [3];
    logic signed [PROD_BITS-1:0] vv_reg [3];
    logic [R2_BITS-1:0]          r2_next;
    logic [R2_BITS-1:0]          r2_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                wd_next[a][b] = PROD_BITS'(w_reg[a]) * PROD_BITS'(d_reg[b]);
            end
            dd_next[a] = PROD_BITS'(d_reg[a]) * PROD_BITS'(d_reg[a]);
            ww_next[a] = PROD_BITS'(w_reg[a]) * PROD_BITS'(w_reg[a]);
            vv_next[a] = PROD_BITS'(v_reg[a]) * PROD_BITS'(v_reg[a]);
        end
        r2_next = R2_BITS'(hit_radius_reg) * R2_BITS'(hit_radius_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            wd_reg <= wd_next;
            dd_reg <= dd_next;
            ww_reg <= ww_next;
            vv_reg <= vv_next;
            r2_reg <= r2_next;
        end
    end

    // stage 3: dot sums and cross magnitudes
    logic signed [DOT_BITS-1:0]  t_next;
    logic [DOT_BITS-1:0]         len2_next;
    logic [DOT_BITS-1:0]         wsum_next;
    logic [DOT_BITS-1:0]         vsum_next;
    logic signed [PROD_BITS:0]   cr [3];
    logic signed [PROD_BITS:0]   crn [3];
    logic [MAG_BITS-1:0]         crm_next [3];
    logic signed [DOT_BITS-1:0]  t_reg;
    logic [DOT_BITS-1:0]         len2_reg;
    logic [DOT_BITS-1:0]         wsum_reg;
    logic [DOT_BITS-1:0]         vsum_reg;
    logic [MAG_BITS-1:0]         crm_reg [3];
    logic [R2_BITS-1:0]          r2b_reg;

    always_comb
    begin
        t_next    = DOT_BITS'(wd_reg[0][0]) + DOT_BITS'(wd_reg[1][1])
                  + DOT_BITS'(wd_reg[2][2]);
        len2_next = DOT_BITS'(dd_reg[0]) + DOT_BITS'(dd_reg[1]) + DOT_BITS'(dd_reg[2]);
        wsum_next = DOT_BITS'(ww_reg[0]) + DOT_BITS'(ww_reg[1]) + DOT_BITS'(ww_reg[2]);
        vsum_next = DOT_BITS'(vv_reg[0]) + DOT_BITS'(vv_reg[1]) + DOT_BITS'(vv_reg[2]);
        cr[0] = (PROD_BITS+1)'(wd_reg[1][2]) - (PROD_BITS+1)'(wd_reg[2][1]);
        cr[1] = (PROD_BITS+1)'(wd_reg[2][0]) - (PROD_BITS+1)'(wd_reg[0][2]);
        cr[2] = (PROD_BITS+1)'(wd_reg[0][1]) - (PROD_BITS+1)'(wd_reg[1][0]);
        for (int k = 0; k < 3; k++)
        begin
            crn[k]      = -cr[k];
            crm_next[k] = cr[k][PROD_BITS] ? crn[k][MAG_BITS-1:0] : cr[k][MAG_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            t_reg    <= t_next;
            len2_reg <= len2_next;
            wsum_reg <= wsum_next;
            vsum_reg <= vsum_next;
            crm_reg  <= crm_next;
            r2b_reg  <= r2_reg;
        end
    end

    // stage 4: region, end-point test, partial products
    region_t                 region_a_next;
    logic                    hit_end_a_next;
    logic [DOT_BITS-1:0]     dist_end;
    sq_parts_t               parts_next [3];
    logic [R2_HI+L_HI-1:0]   rhlh_next;
    logic [R2_HI+L_LO-1:0]   rhll_next;
    logic [R2_LO+L_HI-1:0]   rllh_next;
    logic [R2_LO+L_LO-1:0]   rlll_next;
    region_t                 region_a_reg;
    logic                    hit_end_a_reg;
    sq_parts_t               parts_reg [3];
    logic [R2_HI+L_HI-1:0]   rhlh_reg;
    logic [R2_HI+L_LO-1:0]   rhll_reg;
    logic [R2_LO+L_HI-1:0]   rllh_reg;
    logic [R2_LO+L_LO-1:0]   rlll_reg;

    for (genvar g = 0; g < 3; g++)
    begin : g_sq
        psp_sq_parts u_sq (
            .mag   (crm_reg[g]),
            .parts (parts_next[g])
        );
    end

    always_comb
    begin
        if (t_reg[DOT_BITS-1] || (t_reg == '0))
        begin
            region_a_next = REGION_START;
        end
        else if ($unsigned(t_reg) >= len2_reg)
        begin
            region_a_next = REGION_END;
        end
        else
        begin
            region_a_next = REGION_INTERIOR;
        end
        dist_end       = (region_a_next == REGION_START) ? wsum_reg : vsum_reg;
        hit_end_a_next = dist_end <= DOT_BITS'(r2b_reg);
        rhlh_next = (R2_HI+L_HI)'(r2b_reg[R2_BITS-1:R2_LO])
                  * (R2_HI+L_HI)'(len2_reg[DOT_BITS-1:L_LO]);
        rhll_next = (R2_HI+L_LO)'(r2b_reg[R2_BITS-1:R2_LO])
                  * (R2_HI+L_LO)'(len2_reg[L_LO-1:0]);
        rllh_next = (R2_LO+L_HI)'(r2b_reg[R2_LO-1:0])
                  * (R2_LO+L_HI)'(len2_reg[DOT_BITS-1:L_LO]);
        rlll_next = (R2_LO+L_LO)'(r2b_reg[R2_LO-1:0])
                  * (R2_LO+L_LO)'(len2_reg[L_LO-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            region_a_reg  <= region_a_next;
            hit_end_a_reg <= hit_end_a_next;
            parts_reg     <= parts_next;
            rhlh_reg      <= rhlh_next;
            rhll_reg      <= rhll_next;
            rllh_reg      <= rllh_next;
            rlll_reg      <= rlll_next;
        end
    end

    // stage 5: assemble squares and r^2 * L
    logic [SQ_BITS-1:0]  crsq_next [3];
    logic [R2L_BITS-1:0] r2l_next;
    logic [SQ_BITS-1:0]  crsq_reg [3];
    logic [R2L_BITS-1:0] r2l_b_reg;
    region_t             region_b_reg;
    logic                hit_end_b_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            crsq_next[k] = (SQ_BITS'(parts_reg[k].hh) << (2*HALF_LO))
                         + (SQ_BITS'(parts_reg[k].hl) << (HALF_LO+1))
                         + SQ_BITS'(parts_reg[k].ll);
        end
        r2l_next = (R2L_BITS'(rhlh_reg) << (R2_LO+L_LO))
                 + (R2L_BITS'(rhll_reg) << R2_LO)
                 + (R2L_BITS'(rllh_reg) << L_LO)
                 + R2L_BITS'(rlll_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            crsq_reg      <= crsq_next;
            r2l_b_reg     <= r2l_next;
            region_b_reg  <= region_a_reg;
            hit_end_b_reg <= hit_end_a_reg;
        end
    end

    // stage 6: squared cross norm
    logic [SUM_BITS-1:0] crsum_next;
    logic [SUM_BITS-1:0] crsum_reg;
    logic [R2L_BITS-1:0] r2l_c_reg;
    region_t             region_c_reg;
    logic                hit_end_c_reg;

    assign crsum_next = SUM_BITS'(crsq_reg[0]) + SUM_BITS'(crsq_reg[1])
                      + SUM_BITS'(crsq_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            crsum_reg     <= crsum_next;
            r2l_c_reg     <= r2l_b_reg;
            region_c_reg  <= region_b_reg;
            hit_end_c_reg <= hit_end_b_reg;
        end
    end

    // stage 7: final compare, output register
    logic    hit_next;
    logic    hit_reg;
    region_t region_reg;

    assign hit_next = (region_c_reg == REGION_INTERIOR)
                    ? (crsum_reg <= SUM_BITS'(r2l_c_reg)) : hit_end_c_reg;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            hit_reg    <= hit_next;
            region_reg <= region_c_reg;
        end
    end

    assign m_tdata = {{(OUT_TDATA_BITS-3){1'b0}}, region_reg, hit_reg};

endmodule
